// ----- hw/rtl/sliding_window_percentile_assert.svh -----
// Assertion macros shared by the sliding window percentile RTL.
`ifndef SLIDING_WINDOW_PERCENTILE_ASSERT_SVH
`define SLIDING_WINDOW_PERCENTILE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SWP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SWP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/swp_pkg.sv -----
// Package: types and codes of the sliding window percentile block.
package swp_pkg;

  localparam int CfgRegs = 2;
  localparam int CfgWidth = 7;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_RANK_COUNT = 1'b1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [CfgWidth-1:0] WINDOW_RESET = 7'd64;
  localparam logic [CfgWidth-1:0] RANK_RESET = 7'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_TAIL,
    S_EVAL,
    S_OUT
  } state_t;

  // Sequencer to rank unit.
  typedef struct packed {
    logic job_start;
    logic pass_clr;
    logic elem_vld;
    logic pass_next;
  } rank_ctl_t;

  // Rank unit to sequencer.
  typedef struct packed {
    logic found;
  } rank_stat_t;

endpackage

// ----- hw/rtl/sliding_window_percentile.sv -----
// Top level: sliding window rank-th largest sample selector.
// A request whose window holds fewer samples than the rank skips the scan;
//   otherwise the rank unit runs passes over the samples held.
// Each pass scans the ring once through its single read port; the number of passes
//   is the number of distinct values from the maximum down to the reported one (1..rank).
// One request at a time; the next is taken once the result sits in the output
//   register. Synchronous active-low reset empties the window; the ring itself
//   holds no reset and entries are only read after being written.
`include "sliding_window_percentile_assert.svh"
module sliding_window_percentile import swp_pkg::*; #(
  parameter int MAX_WINDOW = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,   // [31:0] sample
  input  logic                in_tuser,   // [0] command
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // [31:0] rank_value, [38:32] fill_level, [39] zero
  output logic                out_tuser,  // [0] rank_valid
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CfgWidth-1:0] cfg_wdata
);

  localparam int PW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int MW = (CW > CfgWidth) ? CW : CfgWidth;

  // Configuration registers.
  logic [CfgWidth-1:0] window_r;
  logic [CfgWidth-1:0] rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      rank_r <= RANK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_r <= cfg_wdata;
        REG_RANK_COUNT:    rank_r <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // Zero means one for both; window saturates at the ring depth.
  logic [CfgWidth-1:0] rank_eff;
  logic [CW-1:0]       window_eff;

  assign rank_eff = (rank_r == '0) ? CfgWidth'(1) : rank_r;

  always_comb begin
    if (window_r == '0) begin
      window_eff = CW'(1);
    end else if (MW'(window_r) > MW'(MAX_WINDOW)) begin
      window_eff = CW'(MAX_WINDOW);
    end else begin
      window_eff = CW'(window_r);
    end
  end

  // Window bookkeeping.
  state_t   state_r, state_nxt;
  logic     in_fire;
  logic     is_push;
  logic [PW-1:0] wslot_r, wslot_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] held_inc;
  logic          enough_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire = in_tvalid && in_tready;
  assign is_push = (in_tuser == CMD_PUSH);

  always_comb begin
    wslot_nxt = wslot_r;
    held_nxt = held_r;
    held_inc = (held_r == CW'(MAX_WINDOW)) ? held_r : held_r + CW'(1);
    if (in_fire) begin
      if (is_push) begin
        wslot_nxt = (wslot_r == PW'(MAX_WINDOW - 1)) ? '0 : wslot_r + PW'(1);
        // Drop every sample beyond the window at once, even after a shrink.
        held_nxt = (held_inc > window_eff) ? window_eff : held_inc;
      end else begin
        held_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r <= '0;
      held_r <= '0;
      enough_r <= 1'b0;
    end else begin
      wslot_r <= wslot_nxt;
      held_r <= held_nxt;
      if (in_fire) begin
        enough_r <= MW'(held_nxt) >= MW'(rank_eff);
      end
    end
  end

  // Scan pointers: walk backward from the newest held sample.
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] rd_idx_r;
  logic          rd_vld_r;
  logic          last_rd;

  assign last_rd = (rd_idx_r == held_r - CW'(1));

  always_ff @(posedge clk) begin
    if (state_r == S_START) begin
      rd_ptr_r <= (wslot_r == '0) ? PW'(MAX_WINDOW - 1) : wslot_r - PW'(1);
      rd_idx_r <= '0;
    end else if (state_r == S_SCAN) begin
      rd_ptr_r <= (rd_ptr_r == '0) ? PW'(MAX_WINDOW - 1) : rd_ptr_r - PW'(1);
      rd_idx_r <= rd_idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_SCAN);
    end
  end

  // Ring memory.
  logic [SAMPLE_BITS-1:0] rd_data;

  swp_ring #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (in_fire && is_push),
    .waddr (wslot_r),
    .wdata (SAMPLE_BITS'(in_tdata)),
    .raddr (rd_ptr_r),
    .rdata (rd_data)
  );

  // Shared compare unit.
  rank_ctl_t              ctl;
  rank_stat_t             stat;
  logic [SAMPLE_BITS-1:0] best;

  swp_rank_unit #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rank (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .elem  (rd_data),
    .rank  (rank_eff),
    .best  (best),
    .stat  (stat)
  );

  // Output register; frees the sequencer as soon as the result is loaded.
  logic        out_load;
  logic        out_tvalid_r;
  logic [31:0] out_value_r;
  logic        out_ok_r;
  logic [6:0]  out_fill_r;

  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (MW'(held_nxt) >= MW'(rank_eff)) ? S_START : S_OUT;
        end
      end
      S_START: state_nxt = S_SCAN;
      S_SCAN: begin
        if (last_rd) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: state_nxt = S_EVAL;
      S_EVAL: state_nxt = stat.found ? S_OUT : S_START;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs to the compare unit.
  always_comb begin
    ctl.job_start = in_fire;
    ctl.pass_clr = (state_r == S_START);
    ctl.elem_vld = rd_vld_r;
    ctl.pass_next = (state_r == S_EVAL) && !stat.found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= enough_r ? 32'(best) : '0;
      out_ok_r <= enough_r;
      out_fill_r <= 7'(held_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = {1'b0, out_fill_r, out_value_r};
  assign out_tuser = out_ok_r;

  `SWP_ASSERT_NXT(a_clear_empties, in_fire && (in_tuser == CMD_CLEAR), held_r == '0, "clear left samples held")
  `SWP_ASSERT_IMP(a_held_bound, 1'b1, held_r <= CW'(MAX_WINDOW), "held count beyond ring depth")
  `SWP_ASSERT_IMP(a_scan_in_range, state_r == S_SCAN, rd_idx_r < held_r, "scan beyond held samples")

endmodule

// ----- hw/rtl/swp_ring.sv -----
// Sample ring memory: one write port, one registered read port.
module swp_ring import swp_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/swp_rank_unit.sv -----
// Rank unit: per pass, largest value below the bound (none on the first pass) and its multiplicity.
module swp_rank_unit import swp_pkg::*; #(
  parameter int MAX_WINDOW = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rank_ctl_t                        ctl,
  input  logic [SAMPLE_BITS-1:0]           elem,
  input  logic [CfgWidth-1:0]              rank,
  output logic [SAMPLE_BITS-1:0]           best,
  output rank_stat_t                       stat
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int MW = (CW > CfgWidth) ? CW : CfgWidth;

  logic [SAMPLE_BITS-1:0] best_r, best_nxt;
  logic [SAMPLE_BITS-1:0] ub_r, ub_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          tot_r, tot_nxt;
  logic                   first_r, first_nxt;
  logic                   have_r, have_nxt;
  logic                   eligible;
  logic [CW-1:0]          sum;

  assign eligible = first_r || (elem < ub_r);
  assign sum = tot_r + cnt_r;

  always_comb begin
    best_nxt = best_r;
    ub_nxt = ub_r;
    cnt_nxt = cnt_r;
    tot_nxt = tot_r;
    first_nxt = first_r;
    have_nxt = have_r;
    if (ctl.job_start) begin
      first_nxt = 1'b1;
      tot_nxt = '0;
    end
    if (ctl.pass_clr) begin
      have_nxt = 1'b0;
      cnt_nxt = '0;
    end
    if (ctl.elem_vld && eligible) begin
      if (!have_r || (elem > best_r)) begin
        best_nxt = elem;
        cnt_nxt = CW'(1);
        have_nxt = 1'b1;
      end else if (elem == best_r) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
    // Step the bound below the current value for the next pass.
    if (ctl.pass_next) begin
      ub_nxt = best_r;
      tot_nxt = sum;
      first_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      have_r <= 1'b0;
      cnt_r <= '0;
      tot_r <= '0;
    end else begin
      first_r <= first_nxt;
      have_r <= have_nxt;
      cnt_r <= cnt_nxt;
      tot_r <= tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    ub_r <= ub_nxt;
  end

  assign best = best_r;
  assign stat.found = MW'(sum) >= MW'(rank);

endmodule

// ----- verif/tb.sv -----
// Testbench for the sliding window percentile block: scoreboard, stimulus and checks.
module tb import swp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Idle cycles with no accepted request on either side before the run is abandoned.
  // The slowest request scans 64 passes over a full ring, plus the longest
  // receiver stall and sender gap; taken several times over.
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // Length of the deliberate receiver hold-off that fills the block up.
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Cycles to keep watching after the last expected result.
  localparam int unsigned TAIL_CYCLES = 200;

  // One expected result: rank value, its valid flag and the fill level.
  typedef struct packed {
    logic [31:0]         value;
    logic                valid;
    logic [CfgWidth-1:0] fill;
  } rank_result_t;

  // Tracks the window contents and the configuration, predicts one result per
  // accepted request and compares it with what the block returns.
  class rank_scoreboard;
    logic [31:0]         ring [64];
    logic [5:0]          write_slot;
    int unsigned         held;
    logic [CfgWidth-1:0] window_reg;
    logic [CfgWidth-1:0] rank_reg;
    rank_result_t        expected_q [$];
    int unsigned         checked;
    int unsigned         mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      write_slot = '0;
      held = 0;
      window_reg = WINDOW_RESET;
      rank_reg = RANK_RESET;
      checked = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic index, logic [CfgWidth-1:0] value);
      if (index == REG_WINDOW_LENGTH) window_reg = value;
      else rank_reg = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note_request(logic command, logic [31:0] sample);
      int unsigned  win;
      int unsigned  rank;
      int unsigned  i;
      int unsigned  j;
      logic [31:0]  vals [64];
      logic [31:0]  tmp;
      rank_result_t res;
      win = (window_reg == 0) ? 1 : ((window_reg > 64) ? 64 : window_reg);
      rank = (rank_reg == 0) ? 1 : rank_reg;
      if (command == CMD_CLEAR) begin
        // Empty the window; the write slot stays where it is.
        held = 0;
      end else begin
        ring[write_slot] = sample;
        write_slot = write_slot + 6'd1;
        if (held < 64) held++;
        // A shrunk window drops all surplus old samples at once.
        if (held > win) held = win;
      end
      // Gather the held samples, newest first, and sort them largest first.
      for (i = 0; i < held; i++) vals[i] = ring[6'(write_slot - 6'(i + 1))];
      for (i = 1; i < held; i++) begin
        tmp = vals[i];
        j = i;
        while (j > 0 && vals[j-1] < tmp) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = tmp;
      end
      res.valid = (held >= rank);
      res.value = res.valid ? vals[rank-1] : 32'd0;
      res.fill = CfgWidth'(held);
      expected_q.insert(expected_q.size(), res);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 200) $display("ERROR: %s", what);
    endtask

    // Compare one accepted result with the oldest expectation.
    task check_result(logic [31:0] value, logic valid, logic [CfgWidth-1:0] fill,
                      logic pad);
      rank_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: value %h valid %b fill %0d",
                                  value, valid, fill));
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        checked++;
        if (value !== want.value || valid !== want.valid || fill !== want.fill ||
            pad !== 1'b0)
          report_mismatch($sformatf(
            "result %0d: value %h valid %b fill %0d pad %b, want %h %b %0d 0",
            checked, value, valid, fill, pad, want.value, want.valid, want.fill));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata = '0;     // [31:0] sample
  logic                in_tuser = 1'b0;   // [0] command
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [39:0]         out_tdata;         // [31:0] rank_value, [38:32] fill_level, [39] zero
  logic                out_tuser;         // [0] rank_valid
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CfgWidth-1:0] cfg_wdata = '0;

  rank_scoreboard book = new();

  // Both sides drop their random gaps while this is set.
  bit          quiet = 1'b0;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit          hold_off_req = 1'b0;
  // Base of the tie-heavy sample cluster in the current phase.
  logic [31:0] tie_base = '0;
  int unsigned idle_cycles = 0;

  always #4 clk = ~clk;

  sliding_window_percentile dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Gap length: mostly none or short, now and then long, none in quiet stretches.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sample mix: full range, small values, extremes and ties around a base.
  // Narrow phases keep few distinct values so that deep ranks stay cheap to scan.
  function automatic logic [31:0] pick_sample(bit narrow);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (narrow) begin
      if (r < 85) return 32'($urandom_range(0, 7));
      return $urandom();
    end
    if (r < 40) return $urandom();
    if (r < 65) return 32'($urandom_range(0, 15));
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return tie_base + 32'($urandom_range(0, 3));
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  // Valid stays high afterwards, so back-to-back requests never toggle it.
  task automatic send_request(logic command, logic [31:0] sample);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= command;
    in_tdata <= sample;
    do @(posedge clk); while (!in_tready);
    book.note_request(command, sample);
  endtask

  // Withdraw the request and wait until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  // Write both registers back to back; only called while the block is idle.
  task automatic configure(logic [CfgWidth-1:0] win, logic [CfgWidth-1:0] rank);
    cfg_we <= 1'b1;
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_wdata <= win;
    @(posedge clk);
    book.write_reg(REG_WINDOW_LENGTH, win);
    cfg_index <= REG_RANK_COUNT;
    cfg_wdata <= rank;
    @(posedge clk);
    book.write_reg(REG_RANK_COUNT, rank);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request, counted here.
  initial begin
    int unsigned stall_left;
    int unsigned g;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          stall_left = g - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      book.check_result(out_tdata[31:0], out_tuser, out_tdata[38:32], out_tdata[39]);
  end

  // Abandon the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned         p;
    int unsigned         k;
    int unsigned         n;
    int unsigned         clear_pct;
    logic [CfgWidth-1:0] win;
    logic [CfgWidth-1:0] rank;
    bit                  narrow;
    logic                cmd;

    // Hold reset, then release it once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration first: maximum over the extremes.
    send_request(CMD_PUSH, 32'h0000_0000);
    send_request(CMD_PUSH, 32'hFFFF_FFFF);
    send_request(CMD_PUSH, 32'h8000_0000);
    send_request(CMD_PUSH, 32'h7FFF_FFFF);
    // Clear, then clear an already empty window.
    send_request(CMD_CLEAR, 32'h5A5A_A5A5);
    send_request(CMD_CLEAR, 32'h0000_0000);
    // Window length zero acts as one, rank zero as the maximum.
    drain_results();
    configure(7'd0, 7'd0);
    send_request(CMD_PUSH, 32'd5);
    send_request(CMD_PUSH, 32'd3);
    // Oversized window saturates; a rank above the held count is not valid.
    drain_results();
    configure(7'd127, 7'd127);
    send_request(CMD_PUSH, 32'd1);
    send_request(CMD_PUSH, 32'd2);
    // Fill a window of eight with ties, third largest counts equal values apart.
    drain_results();
    configure(7'd8, 7'd3);
    send_request(CMD_PUSH, 32'd4);
    send_request(CMD_PUSH, 32'd4);
    send_request(CMD_PUSH, 32'd4);
    send_request(CMD_PUSH, 32'd1);
    send_request(CMD_PUSH, 32'd9);
    send_request(CMD_PUSH, 32'd9);
    send_request(CMD_PUSH, 32'd2);
    send_request(CMD_PUSH, 32'd4);
    // Shrink the full window: the next push keeps only the newest three.
    drain_results();
    configure(7'd3, 7'd1);
    send_request(CMD_PUSH, 32'd6);
    // Full-size window with a rank far above the held count.
    drain_results();
    configure(7'd64, 7'd64);
    send_request(CMD_PUSH, 32'd7);

    // Random phases; each starts from an idle block with a fresh setting.
    for (p = 0; p < 12; p++) begin
      drain_results();
      narrow = 1'b0;
      clear_pct = 4;
      quiet = (p == 0 || p == 3 || p == 7 || p == 11);
      tie_base = $urandom();
      case (p)
        0: begin win = 7'd64; rank = 7'd1; n = 60; end
        1: begin win = 7'd1; rank = 7'd1; n = 40; end
        2: begin win = 7'd64; rank = 7'd64; n = 90; narrow = 1'b1; clear_pct = 1; end
        3: begin win = 7'd127; rank = 7'd127; n = 20; end
        4: begin win = 7'd0; rank = 7'd0; n = 25; end
        5: begin win = 7'd2; rank = 7'd2; n = 40; end
        6: begin win = 7'd64; rank = 7'($urandom_range(1, 8)); n = 50; end
        default: begin
          win = 7'($urandom_range(1, 64));
          if (p == 9) begin
            // Deepest rank of the window: the minimum once full.
            rank = win;
            narrow = 1'b1;
            clear_pct = 1;
          end else begin
            rank = 7'($urandom_range(1, (win < 8) ? win : 8));
          end
          n = 45;
        end
      endcase
      configure(win, rank);
      // Stall the receiver for a long stretch while requests keep coming.
      if (p == 0) hold_off_req = 1'b1;
      for (k = 0; k < n; k++) begin
        cmd = ($urandom_range(0, 99) < clear_pct) ? CMD_CLEAR : CMD_PUSH;
        send_request(cmd, pick_sample(narrow));
      end
    end

    // Wait for the tail of results, then watch a while for strays.
    quiet = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/swp_pkg.sv
hw/rtl/swp_ring.sv
hw/rtl/swp_rank_unit.sv
hw/rtl/sliding_window_percentile.sv
verif/tb.sv
